FILE: rtl/mt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 package
// Shared constants for the Mersenne Twister generator.
// ----------------------------------------------------------------------------
package mt_pkg;
    localparam int unsigned TABLE_WORDS   = 624;
    localparam int unsigned MIDDLE_OFFSET = 397;
    localparam int unsigned IDX_W         = 10;
    localparam logic [31:0] TWIST_MATRIX  = 32'h9908B0DF;
    localparam logic [31:0] HIGH_BIT      = 32'h80000000;
    localparam logic [31:0] LOW_BITS      = 32'h7FFFFFFF;
    localparam logic [31:0] MULT_PLAIN    = 32'd1812433253;
    localparam logic [31:0] MULT_ARR1     = 32'd1664525;
    localparam logic [31:0] MULT_ARR2     = 32'd1566083941;
    localparam logic [31:0] ARRAY_BASE    = 32'd19650218;
    localparam logic [31:0] TEMPER_B      = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C      = 32'hEFC60000;

    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_RAW    = 2'd1;
    localparam logic [1:0] OP_BOUND  = 2'd2;

    localparam logic CFG_SEED_WORD = 1'b0;
    localparam logic CFG_SEED_MODE = 1'b1;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage

FILE: rtl/mt19937_random_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 random generator unit
// Table held in a single-port-write, single-read memory; one shared
// 32x32 multiplier serves the seed recurrences.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes an opcode (0 reseed, 1 raw draw, 2 draw below bound)
//   and a bound. m_ channel returns one 32-bit word per item (0 for reseed,
//   opcode 3 and bounds below 2). cfg channel writes seed_word (index 0) and seed_mode (index 1).
// Flow (one item at a time; s_ready is low while an item is at work):
//   raw draw: table read, wait, then a check state fills the result register.
//   twist: three reads, one write per word; 624 words; run when table is used up.
//   plain seed: multiply, write per word; array seed adds two passes of read,
//   wait, multiply, write, check. The read port and the multiplier set these.
//   bounded draw: one raw draw per attempt until the draw fits.
// Reset: seed_word=42, seed_mode=1, table marked unseeded; the first draw
//   seeds first. No clearing pass.
// Stall: the result register holds until m_ready; the next word may be
//   taken meanwhile and waits at its own result until the register frees.
// ----------------------------------------------------------------------------
module mt19937_random_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [30:0] s_bound,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int unsigned IW = mt_pkg::IDX_W;
    localparam logic [IW-1:0] LAST  = IW'(mt_pkg::TABLE_WORDS - 1);
    localparam logic [IW-1:0] NWORD = IW'(mt_pkg::TABLE_WORDS);
    localparam logic [IW-1:0] UNSEED = IW'(mt_pkg::TABLE_WORDS + 1);
    localparam logic [IW-1:0] MIDOFF = IW'(mt_pkg::MIDDLE_OFFSET);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DISP  = 5'd1;
    localparam logic [4:0] ST_PS_RD = 5'd2;
    localparam logic [4:0] ST_PS_MU = 5'd3;
    localparam logic [4:0] ST_PS_WR = 5'd4;
    localparam logic [4:0] ST_AS_RD = 5'd5;
    localparam logic [4:0] ST_AS_R2 = 5'd6;
    localparam logic [4:0] ST_AS_MU = 5'd7;
    localparam logic [4:0] ST_AS_WR = 5'd8;
    localparam logic [4:0] ST_AS_W0 = 5'd9;
    localparam logic [4:0] ST_TW_R0 = 5'd10;
    localparam logic [4:0] ST_TW_R1 = 5'd11;
    localparam logic [4:0] ST_TW_R2 = 5'd12;
    localparam logic [4:0] ST_TW_WR = 5'd13;
    localparam logic [4:0] ST_DR_RD = 5'd14;
    localparam logic [4:0] ST_DR_WT = 5'd15;
    localparam logic [4:0] ST_DR_CK = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;
    localparam logic [4:0] ST_AS_FIN = 5'd18;

    logic [31:0] table_mem [mt_pkg::TABLE_WORDS];
    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic [31:0]   rd_data_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) table_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= table_mem[rd_addr];
    end

    logic [4:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;      // read index
    logic [IW-1:0] k_reg, k_next;          // loop position
    logic [IW-1:0] cnt_reg, cnt_next;      // array pass counter
    logic          pass_reg, pass_next;    // array seeding pass
    logic [31:0]   prev_reg, prev_next;    // last word written / first operand
    logic [31:0]   cur_reg, cur_next;
    logic [31:0]   prod_reg, prod_next;
    logic [31:0]   seed_word_reg;
    logic          seed_mode_reg;
    logic [1:0]    op_reg;
    logic [30:0]   bound_reg;
    logic [4:0]    bits_reg;
    logic          mval_reg, mval_next;
    logic [31:0]   mvalue_reg, mvalue_next;
    logic          after_seed_reg, after_seed_next; // seeding done inside a draw
    logic          out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = mval_reg;
    assign m_value   = mvalue_reg;
    assign cfg_ready = 1'b1;
    // result register can take a new word this cycle
    assign out_free  = !mval_reg || m_ready;

    // bit length of bound
    logic [4:0] blen;
    always_comb begin
        blen = 5'd0;
        for (int b = 0; b < 31; b++) begin
            if (s_bound[b]) blen = 5'(b + 1);
        end
    end

    logic [31:0] mult_a, mult_b, mult_p;
    assign mult_p = mult_a * mult_b;

    logic [IW-1:0] k_inc, k_mid;
    logic [IW:0]   mid_sum;
    assign k_inc   = (k_reg == LAST) ? '0 : k_reg + 1'b1;
    assign mid_sum = {1'b0, k_reg} + {1'b0, MIDOFF};
    assign k_mid   = (mid_sum >= (IW+1)'(mt_pkg::TABLE_WORDS))
                   ? IW'(mid_sum - (IW+1)'(mt_pkg::TABLE_WORDS)) : mid_sum[IW-1:0];

    logic [31:0] tw_y, tw_word, drawn, shifted;
    assign tw_y    = (cur_reg & mt_pkg::HIGH_BIT) | (rd_data_reg & mt_pkg::LOW_BITS);
    assign tw_word = prev_reg ^ (tw_y >> 1) ^ (tw_y[0] ? mt_pkg::TWIST_MATRIX : 32'd0);
    assign drawn   = mt_pkg::temper(rd_data_reg);
    assign shifted = drawn >> (6'd32 - {1'b0, bits_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_word_reg <= 32'd42;
            seed_mode_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == mt_pkg::CFG_SEED_WORD) seed_word_reg <= cfg_data;
            else seed_mode_reg <= cfg_data[0];
        end
        if (s_valid && s_ready) begin
            op_reg    <= s_opcode;
            bound_reg <= s_bound;
            bits_reg  <= blen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= UNSEED;
            mval_reg       <= 1'b0;
            after_seed_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            mval_reg       <= mval_next;
            after_seed_reg <= after_seed_next;
        end
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        pass_reg   <= pass_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        prod_reg   <= prod_next;
        mvalue_reg <= mvalue_next;
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        cnt_next = cnt_reg;
        pass_next = pass_reg;
        prev_next = prev_reg;
        cur_next = cur_reg;
        prod_next = prod_reg;
        mval_next = mval_reg;
        mvalue_next = mvalue_reg;
        after_seed_next = after_seed_reg;
        rd_en = 1'b0;
        rd_addr = k_reg;
        wr_en = 1'b0;
        wr_addr = k_reg;
        wr_data = prev_reg;
        mult_a = prev_reg ^ (prev_reg >> 30);
        mult_b = mt_pkg::MULT_PLAIN;
        if (mval_reg && m_ready) mval_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) state_next = ST_DISP;
            end
            ST_DISP: begin
                // start plain seeding at word 0 (seed or array base)
                if (op_reg == mt_pkg::OP_RESEED
                    || ((op_reg == mt_pkg::OP_RAW
                         || (op_reg == mt_pkg::OP_BOUND && bound_reg > 31'd1))
                        && idx_reg == UNSEED)) begin
                    after_seed_next = (op_reg != mt_pkg::OP_RESEED);
                    prev_next = seed_mode_reg ? mt_pkg::ARRAY_BASE : seed_word_reg;
                    wr_en = 1'b1;
                    wr_addr = '0;
                    wr_data = seed_mode_reg ? mt_pkg::ARRAY_BASE : seed_word_reg;
                    k_next = IW'(1);
                    state_next = ST_PS_MU;
                end else if (op_reg == mt_pkg::OP_RAW
                             || (op_reg == mt_pkg::OP_BOUND && bound_reg > 31'd1)) begin
                    state_next = ST_DR_RD;
                end else if (out_free) begin
                    mvalue_next = 32'd0;
                    mval_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_PS_MU: begin
                prod_next = mult_p;
                state_next = ST_PS_WR;
            end
            ST_PS_WR: begin
                wr_en = 1'b1;
                wr_data = prod_reg + 32'(k_reg);
                prev_next = prod_reg + 32'(k_reg);
                if (k_reg == LAST) begin
                    if (seed_mode_reg) begin
                        // array passes start at word 1, chained from word 0
                        prev_next = mt_pkg::ARRAY_BASE;
                        k_next = IW'(1);
                        cnt_next = NWORD;
                        pass_next = 1'b0;
                        state_next = ST_AS_RD;
                    end else begin
                        idx_next = NWORD;
                        state_next = after_seed_reg ? ST_DR_RD : ST_PS_RD;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_PS_MU;
                end
            end
            ST_PS_RD: begin
                // reseed done
                if (out_free) begin
                    mvalue_next = 32'd0;
                    mval_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_AS_RD: begin
                // prev_reg holds table[k-1]
                rd_en = 1'b1;
                state_next = ST_AS_R2;
            end
            ST_AS_R2: begin
                state_next = ST_AS_MU;
            end
            ST_AS_MU: begin
                mult_b = pass_reg ? mt_pkg::MULT_ARR2 : mt_pkg::MULT_ARR1;
                prod_next = rd_data_reg ^ mult_p;
                state_next = ST_AS_WR;
            end
            ST_AS_WR: begin
                wr_en = 1'b1;
                wr_data = pass_reg ? prod_reg - 32'(k_reg) : prod_reg + seed_word_reg;
                prev_next = wr_data;
                cnt_next = cnt_reg - 1'b1;
                if (k_reg == LAST) begin
                    k_next = IW'(1);
                    state_next = ST_AS_W0;
                end else begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_AS_FIN;
                end
            end
            ST_AS_W0: begin
                // wrap: table[0] = table[last]; prev already holds it
                wr_en = 1'b1;
                wr_addr = '0;
                state_next = ST_AS_FIN;
            end
            ST_AS_FIN: begin
                if (cnt_reg == '0) begin
                    if (!pass_reg) begin
                        pass_next = 1'b1;
                        cnt_next = LAST;
                        state_next = ST_AS_RD;
                    end else begin
                        wr_en = 1'b1;
                        wr_addr = '0;
                        wr_data = mt_pkg::HIGH_BIT;
                        idx_next = NWORD;
                        state_next = after_seed_reg ? ST_DR_RD : ST_PS_RD;
                    end
                end else begin
                    state_next = ST_AS_RD;
                end
            end
            ST_TW_R0: begin
                rd_en = 1'b1;
                rd_addr = k_reg;
                state_next = ST_TW_R1;
            end
            ST_TW_R1: begin
                rd_en = 1'b1;
                rd_addr = k_mid;
                cur_next = rd_data_reg;
                state_next = ST_TW_R2;
            end
            ST_TW_R2: begin
                rd_en = 1'b1;
                rd_addr = k_inc;
                prev_next = rd_data_reg;
                state_next = ST_TW_WR;
            end
            ST_TW_WR: begin
                wr_en = 1'b1;
                wr_data = tw_word;
                if (k_reg == LAST) begin
                    idx_next = '0;
                    state_next = ST_DR_RD;
                end else begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_TW_R0;
                end
            end
            ST_DR_RD: begin
                after_seed_next = 1'b0;
                if (idx_reg >= NWORD) begin
                    k_next = '0;
                    state_next = ST_TW_R0;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = idx_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_DR_WT;
                end
            end
            ST_DR_WT: begin
                state_next = ST_DR_CK;
            end
            ST_DR_CK: begin
                // hold here while the previous word still waits
                if (op_reg == mt_pkg::OP_RAW) begin
                    if (out_free) begin
                        mvalue_next = drawn;
                        mval_next = 1'b1;
                        state_next = ST_OUT;
                    end
                end else if (shifted < {1'b0, bound_reg}) begin
                    if (out_free) begin
                        mvalue_next = shifted;
                        mval_next = 1'b1;
                        state_next = ST_OUT;
                    end
                end else begin
                    state_next = ST_DR_RD;
                end
            end
            ST_OUT: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: tb/mt19937_random_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 random generator unit testbench
// Drives reseed, raw and bounded draws under random idling on both channels,
// writes the seed registers between phases, and checks every returned word
// against an in-bench twister model.
// ----------------------------------------------------------------------------
module mt19937_random_generator_unit_tb;

    localparam int unsigned N_WORDS = 624;
    localparam int unsigned MID_OFS = 397;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [30:0] s_bound;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    mt19937_random_generator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_bound(s_bound),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // model state
    logic [31:0] mt_tab [N_WORDS];
    int unsigned mt_idx;
    logic [31:0] mdl_seed;
    logic        mdl_mode;

    logic [31:0] exp_words[$];
    int          n_fail;
    longint      cyc;
    bit          drain_on;

    function automatic logic [31:0] chain(logic [31:0] p, logic [31:0] mult);
        logic [63:0] x;
        x = {32'd0, p ^ (p >> 30)} * {32'd0, mult};
        return x[31:0];
    endfunction

    function automatic void seed_plain(logic [31:0] s);
        mt_tab[0] = s;
        for (int i = 1; i < N_WORDS; i++)
            mt_tab[i] = chain(mt_tab[i-1], mt_pkg::MULT_PLAIN) + 32'(i);
        mt_idx = N_WORDS;
    endfunction

    function automatic void seed_array(logic [31:0] key);
        int unsigned i;
        i = 1;
        seed_plain(mt_pkg::ARRAY_BASE);
        for (int k = N_WORDS; k != 0; k--) begin
            mt_tab[i] = (mt_tab[i] ^ chain(mt_tab[i-1], mt_pkg::MULT_ARR1)) + key;
            i++;
            if (i >= N_WORDS) begin
                mt_tab[0] = mt_tab[N_WORDS-1];
                i = 1;
            end
        end
        for (int k = N_WORDS - 1; k != 0; k--) begin
            mt_tab[i] = (mt_tab[i] ^ chain(mt_tab[i-1], mt_pkg::MULT_ARR2)) - 32'(i);
            i++;
            if (i >= N_WORDS) begin
                mt_tab[0] = mt_tab[N_WORDS-1];
                i = 1;
            end
        end
        mt_tab[0] = mt_pkg::HIGH_BIT;
        mt_idx = N_WORDS;
    endfunction

    function automatic void reseed_model();
        if (mdl_mode) seed_array(mdl_seed);
        else seed_plain(mdl_seed);
    endfunction

    function automatic logic [31:0] next_word();
        logic [31:0] y;
        int unsigned nx, md;
        if (mt_idx > N_WORDS) reseed_model();
        if (mt_idx >= N_WORDS) begin
            for (int k = 0; k < N_WORDS; k++) begin
                nx = (k + 1 < N_WORDS) ? k + 1 : 0;
                md = (k + MID_OFS) % N_WORDS;
                y = (mt_tab[k] & mt_pkg::HIGH_BIT) | (mt_tab[nx] & mt_pkg::LOW_BITS);
                mt_tab[k] = mt_tab[md] ^ (y >> 1) ^ (y[0] ? mt_pkg::TWIST_MATRIX : 32'd0);
            end
            mt_idx = 0;
        end
        y = mt_tab[mt_idx];
        mt_idx++;
        y ^= y >> 11;
        y ^= (y << 7) & mt_pkg::TEMPER_B;
        y ^= (y << 15) & mt_pkg::TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    function automatic logic [31:0] predict_word(logic [1:0] op, logic [30:0] bnd);
        int unsigned nbits;
        logic [31:0] r;
        case (op)
            mt_pkg::OP_RESEED: begin
                reseed_model();
                return 32'd0;
            end
            mt_pkg::OP_RAW: return next_word();
            mt_pkg::OP_BOUND: begin
                if (bnd <= 1) return 32'd0;
                nbits = $clog2({1'b0, bnd} + 32'd1);
                forever begin
                    r = next_word() >> (32 - nbits);
                    if (r < {1'b0, bnd}) return r;
                end
            end
            default: return 32'd0;
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stall, compare each word
    initial begin : result_side
        int unsigned gap;
        logic [31:0] want;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
            if (exp_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_value);
                n_fail++;
            end else begin
                want = exp_words.pop_front();
                if (m_value !== want) begin
                    $display("%0t: value expected %h actual %h", $time, want, m_value);
                    n_fail++;
                end
            end
        end
    end

    // valid stays up between back-to-back words; wait_idle drops it
    task automatic send_word(logic [1:0] op, logic [30:0] bnd, bit chk, logic [31:0] fixed);
        logic [31:0] p;
        int unsigned gap;
        gap = drain_on ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_bound  <= bnd;
        @(posedge aclk iff s_ready);
        p = predict_word(op, bnd);
        if (chk && p !== fixed) begin
            $display("%0t: model disagrees with table, expected %h actual %h", $time, fixed, p);
            n_fail++;
        end
        // opcode 3 changes nothing but still returns a zero word
        exp_words.push_back(p);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk iff exp_words.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == mt_pkg::CFG_SEED_WORD) mdl_seed = d;
        else mdl_mode = d[0];
        @(posedge aclk);
    endtask

    typedef struct {
        logic [1:0]  op;
        logic [30:0] bnd;
        bit          chk;
        logic [31:0] want;
    } stim_row_t;

    stim_row_t rows [15] = '{
        '{mt_pkg::OP_RAW,    31'd0,          0, 32'd0},
        '{mt_pkg::OP_BOUND,  31'd0,          1, 32'd0},
        '{mt_pkg::OP_BOUND,  31'd1,          1, 32'd0},
        '{OP_NONE,           31'h7FFFFFFF,   1, 32'd0},
        '{mt_pkg::OP_RESEED, 31'h7FFFFFFF,   1, 32'd0},
        '{mt_pkg::OP_BOUND,  31'd2,          0, 32'd0},
        '{mt_pkg::OP_BOUND,  31'd3,          0, 32'd0},
        '{mt_pkg::OP_BOUND,  31'h40000000,   0, 32'd0},
        '{mt_pkg::OP_BOUND,  31'h40000001,   0, 32'd0},
        '{mt_pkg::OP_BOUND,  31'h7FFFFFFF,   0, 32'd0},
        '{mt_pkg::OP_BOUND,  31'h55555555,   0, 32'd0},
        '{mt_pkg::OP_BOUND,  31'h2AAAAAAA,   0, 32'd0},
        '{mt_pkg::OP_RAW,    31'h2AAAAAAA,   0, 32'd0},
        '{mt_pkg::OP_RESEED, 31'd0,          1, 32'd0},
        '{mt_pkg::OP_RAW,    31'd0,          0, 32'd0}
    };

    task automatic random_items(int n);
        logic [1:0] op;
        logic [30:0] bnd;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0:       op = mt_pkg::OP_RESEED;
                1:       op = OP_NONE;
                2,3,4,5,6,7,8,9: op = mt_pkg::OP_RAW;
                default: op = mt_pkg::OP_BOUND;
            endcase
            case ($urandom_range(0, 3))
                0: bnd = 31'($urandom_range(0, 20));
                1: bnd = 31'($urandom) >> $urandom_range(0, 30);
                default: bnd = 31'($urandom);
            endcase
            send_word(op, bnd, 0, 32'd0);
        end
    endtask

    initial begin : stimulus
        s_valid = 1'b0;
        s_opcode = mt_pkg::OP_RAW;
        s_bound = '0;
        cfg_valid = 1'b0;
        cfg_index = mt_pkg::CFG_SEED_WORD;
        cfg_data = '0;
        aresetn = 1'b0;
        cyc = 0;
        n_fail = 0;
        drain_on = 0;
        mt_idx = N_WORDS + 1;
        mdl_seed = 32'd42;
        mdl_mode = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first draw from the reset seed, before any seeding
        foreach (rows[i]) send_word(rows[i].op, rows[i].bnd, rows[i].chk, rows[i].want);
        wait_idle();

        write_reg(mt_pkg::CFG_SEED_MODE, 32'd0);
        write_reg(mt_pkg::CFG_SEED_WORD, 32'd5489);
        send_word(mt_pkg::OP_RESEED, 31'd0, 1, 32'd0);
        // standard plain-seed first output for 5489
        send_word(mt_pkg::OP_RAW, 31'd0, 1, 32'd3499211612);
        random_items(680);   // crosses a twist
        drain_on = 1;
        wait_idle();
        drain_on = 0;

        write_reg(mt_pkg::CFG_SEED_WORD, 32'hFFFFFFFF);
        write_reg(mt_pkg::CFG_SEED_MODE, 32'd1);
        random_items(60);
        wait_idle();
        write_reg(mt_pkg::CFG_SEED_WORD, 32'd0);
        write_reg(mt_pkg::CFG_SEED_MODE, 32'd0);
        random_items(60);
        wait_idle();
        write_reg(mt_pkg::CFG_SEED_MODE, 32'd1);
        random_items(40);
        wait_idle();

        if (n_fail == 0 && exp_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (exp_words.size() != 0) $display("%0t: %0d words never came", $time, exp_words.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
